/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion shorthands used by the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define VAS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition must never be seen at a clock edge outside reset
`define VAS_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

/* hdl/vas_pkg.sv */
// ----------------------------------------------------------------------------
// vas_pkg
// types and constants of the voice allocator
// ----------------------------------------------------------------------------
`default_nettype none

package vas_pkg;

   // sizes fixed by the event format
   localparam int NOTE_W     = 7;
   localparam int VEL_W      = 7;
   localparam int VIDX_OUT_W = 3;
   localparam int NOTE_COUNT = 128;

   // defaults of the top level parameters
   localparam int MAX_VOICES_DEFAULT  = 8;
   localparam int STACK_DEPTH_DEFAULT = 32;

   // csr port
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int VCOUNT_W   = 4;
   localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 4'd8;

   // word index of each csr (paddr bit 2)
   localparam logic REG_VOICE_COUNT = 1'b0;

   // event kinds
   localparam logic REQ_NOTE_ON  = 1'b0;
   localparam logic REQ_NOTE_OFF = 1'b1;

   typedef struct packed {
      logic              req_type;
      logic [NOTE_W-1:0] note_number;
      logic [VEL_W-1:0]  velocity;
   } vas_req_type;

   typedef struct packed {
      logic                  voice_changed;
      logic [VIDX_OUT_W-1:0] voice_index;
      logic                  voice_active;
      logic [NOTE_W-1:0]     voice_note;
      logic [VEL_W-1:0]      voice_velocity;
      logic                  note_stolen;
      logic                  event_dropped;
   } vas_rsp_type;

endpackage

`default_nettype wire

/* hdl/voice_allocator_with_stealing.sv */
// ----------------------------------------------------------------------------
// voice_allocator_with_stealing
// polyphonic voice allocator with last-changed voice stealing
// ----------------------------------------------------------------------------
// Takes one note-on or note-off event per req transfer and returns exactly one
// rsp transfer describing the voice that changed (or an all-quiet result).
// Events are handled one at a time by a small sequencer that walks the held
// note stack and the voice table over a single compare unit; req_ready is high
// only while the sequencer is idle, but a finished result sits in an output
// register so the next event can be taken before the last rsp transfer.
// Per event: a note-on scans the nv voices in use for a free one, and steals
// one when none is free, nv being the voice count clamped to 1..MAX_VOICES. A
// note-off of a held note walks the held-stack memory, which is read one entry
// per cycle, once to squeeze the note out and once to look for a waiting note.
// The per-note table sits in a memory with one valid bit per note, so there
// is no clearing pass after reset. voice_count is written at csr word 0 and
// may only be changed while no event is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module voice_allocator_with_stealing #(
   parameter int MAX_VOICES  = vas_pkg::MAX_VOICES_DEFAULT,
   parameter int STACK_DEPTH = vas_pkg::STACK_DEPTH_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // event transfer
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire vas_pkg::vas_req_type                req_data,
   // result transfer
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output vas_pkg::vas_rsp_type                     rsp_data,
   // csr port
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [vas_pkg::CSR_ADDR_W-1:0]      paddr,
   input  wire logic [vas_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [vas_pkg::CSR_DATA_W-1:0]           prdata,
   output logic                                     pready
);
   import vas_pkg::*;

`include "assert_macros.svh"

   // widths derived from the parameters
   localparam int VW  = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;  // voice index
   localparam int NVW = VW + 1;                                     // voice count
   localparam int AW  = $clog2(STACK_DEPTH);                        // stack address
   localparam int CW  = $clog2(STACK_DEPTH + 1);                    // stack fill

   // per-note table entry
   typedef struct packed {
      logic              held;       // note is in the held stack
      logic              sounding;   // note sits in some voice
      logic [VEL_W-1:0]  level;      // note-on velocity
   } note_entry_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOOKUP,      // per-note entry of the event note arrives
      ST_ON_VSCAN,    // look for the first free voice
      ST_STEAL_RD,    // fetch the entry of the note being pushed out
      ST_STEAL_WR,    // clear its sounding flag, take the voice
      ST_COMPACT,     // squeeze the released note out of the stack
      ST_OFF_VSCAN,   // look for the voice playing the released note
      ST_OFF_DECIDE,
      ST_MONO_RD,     // top of stack arrives, fetch its velocity
      ST_MONO_SET,
      ST_FILL,        // most recent waiting note for the freed voice
      ST_DONE         // hand the result to the output register
   } state_type;

   // ---------------------------------------------------------------------
   // csr: voice_count
   // ---------------------------------------------------------------------
   logic [VCOUNT_W-1:0] vcount_ff;
   logic                csr_wr;

   assign csr_wr = psel && penable && pwrite && pready && (paddr[2] == REG_VOICE_COUNT);
   assign pready = 1'b1;
   assign prdata = (paddr[2] == REG_VOICE_COUNT) ?
                   {{(CSR_DATA_W-VCOUNT_W){1'b0}}, vcount_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff <= VCOUNT_RESET;
      end else if (csr_wr) begin
         vcount_ff <= pwdata[VCOUNT_W-1:0];
      end
   end

   // voice count clamped to 1..MAX_VOICES, sampled with each event
   logic [NVW-1:0] nv_clamped;

   always_comb begin
      if (vcount_ff == '0) begin
         nv_clamped = NVW'(1);
      end else if (int'(vcount_ff) > MAX_VOICES) begin
         nv_clamped = NVW'(MAX_VOICES);
      end else begin
         nv_clamped = NVW'(vcount_ff);
      end
   end

   // ---------------------------------------------------------------------
   // sequencer registers
   // ---------------------------------------------------------------------
   state_type         state_ff, state_in;
   logic              kind_ff, kind_in;
   logic [NOTE_W-1:0] note_ff, note_in;
   logic [VEL_W-1:0]  vel_ff, vel_in;
   logic [NVW-1:0]    nv_ff, nv_in;
   logic [CW-1:0]     cnt_ff, cnt_in;       // held notes
   logic [CW-1:0]     rptr_ff, rptr_in;     // stack read pointer
   logic [CW-1:0]     wptr_ff, wptr_in;     // stack write pointer while compacting
   logic              pend_ff, pend_in;     // stack read data due this cycle
   logic              p2_ff, p2_in;         // note-table read data due this cycle
   logic [NOTE_W-1:0] w_ff, w_in;           // note whose entry is due
   logic [VW-1:0]     vidx_ff, vidx_in;     // voice under work
   logic              freed_ff, freed_in;
   logic [VW-1:0]     last_ff, last_in;     // last changed voice
   vas_rsp_type       res_ff, res_in;
   logic              rsp_valid_ff, rsp_valid_in;
   vas_rsp_type       rsp_data_ff, rsp_data_in;

   // voice table, one read and one write port at vidx_ff
   logic              voice_busy_ff  [MAX_VOICES];
   logic [NOTE_W-1:0] voice_pitch_ff [MAX_VOICES];
   logic              v_we;
   logic              v_wbusy;
   logic [NOTE_W-1:0] v_wpitch;
   logic              busy_sel;
   logic [NOTE_W-1:0] pitch_sel;

   // held stack memory, oldest entry at address 0, newest at cnt-1
   logic [NOTE_W-1:0] stack_mem [STACK_DEPTH];
   logic              stack_we;
   logic [AW-1:0]     stack_waddr;
   logic [NOTE_W-1:0] stack_wdata;
   logic [AW-1:0]     stack_raddr;
   logic [NOTE_W-1:0] stack_q_ff;

   // per-note memory with valid bits standing in for the reset clear
   note_entry_type    note_mem [NOTE_COUNT];
   logic              note_vld_ff [NOTE_COUNT];
   logic              note_we;
   logic [NOTE_W-1:0] note_waddr;
   note_entry_type    note_wdata;
   logic [NOTE_W-1:0] note_raddr;
   note_entry_type    note_q_ff;
   logic              note_qv_ff;
   note_entry_type    nd;               // entry read back, zero if never written

   // shared compare unit
   logic [NOTE_W-1:0] cmp_a;
   logic              cmp_hit;

   // stack helpers
   logic [CW-1:0]     cnt_m1;
   logic [CW-1:0]     rptr_m1;
   logic              vscan_last;
   logic [VW-1:0]     steal_tgt;

   assign busy_sel  = voice_busy_ff[vidx_ff];
   assign pitch_sel = voice_pitch_ff[vidx_ff];
   assign nd        = note_qv_ff ? note_q_ff : '0;
   assign cnt_m1    = cnt_ff - CW'(1);
   assign rptr_m1   = rptr_ff - CW'(1);

   // one voice scan step left when vidx is the last voice in use
   assign vscan_last = (NVW'(vidx_ff) + NVW'(1)) == nv_ff;

   // stealing target: last changed voice if it is still in use, else voice 0
   assign steal_tgt = (NVW'(last_ff) < nv_ff) ? last_ff : '0;

   always_comb begin
      case (state_ff)
         ST_COMPACT:  cmp_a = stack_q_ff;
         ST_STEAL_WR: cmp_a = w_ff;
         default:     cmp_a = pitch_sel;
      endcase
   end

   assign cmp_hit = (cmp_a == note_ff);

   function automatic vas_rsp_type make_rsp(input logic [VIDX_OUT_W-1:0] idx,
                                            input logic                  active,
                                            input logic [NOTE_W-1:0]     nt,
                                            input logic [VEL_W-1:0]      vl,
                                            input logic                  stolen);
      vas_rsp_type r;
      r                = '0;
      r.voice_changed  = 1'b1;
      r.voice_index    = idx;
      r.voice_active   = active;
      r.voice_note     = nt;
      r.voice_velocity = vl;
      r.note_stolen    = stolen;
      return r;
   endfunction

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------------------------------------------------------------
   // sequencer
   // ---------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      note_in      = note_ff;
      vel_in       = vel_ff;
      nv_in        = nv_ff;
      cnt_in       = cnt_ff;
      rptr_in      = rptr_ff;
      wptr_in      = wptr_ff;
      pend_in      = pend_ff;
      p2_in        = p2_ff;
      w_in         = w_ff;
      vidx_in      = vidx_ff;
      freed_in     = freed_ff;
      last_in      = last_ff;
      res_in       = res_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      stack_we     = 1'b0;
      stack_waddr  = wptr_ff[AW-1:0];
      stack_wdata  = stack_q_ff;
      stack_raddr  = rptr_ff[AW-1:0];
      note_we      = 1'b0;
      note_waddr   = note_ff;
      note_wdata   = '0;
      note_raddr   = note_ff;
      v_we         = 1'b0;
      v_wbusy      = 1'b0;
      v_wpitch     = '0;

      unique case (state_ff)
         ST_IDLE: begin
            note_raddr = req_data.note_number;
            if (req_valid) begin
               kind_in  = req_data.req_type;
               note_in  = req_data.note_number;
               vel_in   = req_data.velocity;
               nv_in    = nv_clamped;
               freed_in = 1'b0;
               state_in = ST_LOOKUP;
            end
         end

         ST_LOOKUP: begin
            vidx_in = '0;
            if (kind_ff == REQ_NOTE_ON) begin
               if (nd.held) begin
                  // already held: nothing happens
                  res_in   = '0;
                  state_in = ST_DONE;
               end else if (cnt_ff == CW'(STACK_DEPTH)) begin
                  res_in               = '0;
                  res_in.event_dropped = 1'b1;
                  state_in             = ST_DONE;
               end else begin
                  // push on top of the stack, mark held and sounding
                  stack_we            = 1'b1;
                  stack_waddr         = cnt_ff[AW-1:0];
                  stack_wdata         = note_ff;
                  cnt_in              = cnt_ff + CW'(1);
                  note_we             = 1'b1;
                  note_wdata.held     = 1'b1;
                  note_wdata.sounding = 1'b1;
                  note_wdata.level    = vel_ff;
                  state_in            = ST_ON_VSCAN;
               end
            end else begin
               // release clears the note entry whether held or not
               note_we = 1'b1;
               if (nd.held) begin
                  rptr_in  = '0;
                  wptr_in  = '0;
                  pend_in  = 1'b0;
                  state_in = ST_COMPACT;
               end else begin
                  state_in = ST_OFF_VSCAN;
               end
            end
         end

         ST_ON_VSCAN: begin
            if (!busy_sel) begin
               v_we     = 1'b1;
               v_wbusy  = 1'b1;
               v_wpitch = note_ff;
               last_in  = vidx_ff;
               res_in   = make_rsp(VIDX_OUT_W'(vidx_ff), 1'b1, note_ff, vel_ff, 1'b0);
               state_in = ST_DONE;
            end else if (vscan_last) begin
               vidx_in  = steal_tgt;
               state_in = ST_STEAL_RD;
            end else begin
               vidx_in = vidx_ff + VW'(1);
            end
         end

         ST_STEAL_RD: begin
            note_raddr = pitch_sel;
            w_in       = pitch_sel;
            state_in   = ST_STEAL_WR;
         end

         ST_STEAL_WR: begin
            // old note keeps held and level, loses its voice; the new note
            // keeps sounding if it happens to be the same note
            if (busy_sel) begin
               note_we             = 1'b1;
               note_waddr          = w_ff;
               note_wdata.held     = nd.held;
               note_wdata.sounding = cmp_hit;
               note_wdata.level    = nd.level;
            end
            v_we     = 1'b1;
            v_wbusy  = 1'b1;
            v_wpitch = note_ff;
            res_in   = make_rsp(VIDX_OUT_W'(vidx_ff), 1'b1, note_ff, vel_ff, 1'b1);
            state_in = ST_DONE;
         end

         ST_COMPACT: begin
            // rewrite every entry but the released note, those above it one place down
            if (pend_ff && !cmp_hit) begin
               stack_we = 1'b1;
               wptr_in  = wptr_ff + CW'(1);
            end
            if (rptr_ff != cnt_ff) begin
               rptr_in = rptr_ff + CW'(1);
               pend_in = 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  cnt_in   = cnt_m1;
                  vidx_in  = '0;
                  state_in = ST_OFF_VSCAN;
               end
            end
         end

         ST_OFF_VSCAN: begin
            if (busy_sel && cmp_hit) begin
               v_we     = 1'b1;
               last_in  = vidx_ff;
               freed_in = 1'b1;
               state_in = ST_OFF_DECIDE;
            end else if (vscan_last) begin
               state_in = ST_OFF_DECIDE;
            end else begin
               vidx_in = vidx_ff + VW'(1);
            end
         end

         ST_OFF_DECIDE: begin
            if ((nv_ff == NVW'(1)) && (cnt_ff != '0)) begin
               // single voice: voice 0 takes the newest held note
               stack_raddr = cnt_m1[AW-1:0];
               vidx_in     = '0;
               state_in    = ST_MONO_RD;
            end else if (freed_ff) begin
               rptr_in  = cnt_ff;
               pend_in  = 1'b0;
               p2_in    = 1'b0;
               state_in = ST_FILL;
            end else begin
               res_in   = '0;
               state_in = ST_DONE;
            end
         end

         ST_MONO_RD: begin
            note_raddr = stack_q_ff;
            w_in       = stack_q_ff;
            state_in   = ST_MONO_SET;
         end

         ST_MONO_SET: begin
            v_we     = 1'b1;
            v_wbusy  = 1'b1;
            v_wpitch = w_ff;
            last_in  = '0;
            res_in   = make_rsp('0, 1'b1, w_ff, nd.level, 1'b0);
            state_in = ST_DONE;
         end

         ST_FILL: begin
            // two stage walk from the top: stack entry, then its note entry
            if (p2_ff && !nd.sounding) begin
               v_we                = 1'b1;
               v_wbusy             = 1'b1;
               v_wpitch            = w_ff;
               note_we             = 1'b1;
               note_waddr          = w_ff;
               note_wdata.held     = nd.held;
               note_wdata.sounding = 1'b1;
               note_wdata.level    = nd.level;
               last_in             = vidx_ff;
               res_in   = make_rsp(VIDX_OUT_W'(vidx_ff), 1'b1, w_ff, nd.level, 1'b0);
               state_in = ST_DONE;
            end else begin
               note_raddr = stack_q_ff;
               if (pend_ff) begin
                  w_in = stack_q_ff;
               end
               p2_in = pend_ff;
               if (rptr_ff != '0) begin
                  stack_raddr = rptr_m1[AW-1:0];
                  rptr_in     = rptr_m1;
                  pend_in     = 1'b1;
               end else begin
                  pend_in = 1'b0;
                  if (!pend_ff && !p2_ff) begin
                     // nobody waiting: report the voice as freed
                     res_in   = make_rsp(VIDX_OUT_W'(vidx_ff), 1'b0, '0, '0, 1'b0);
                     state_in = ST_DONE;
                  end
               end
            end
         end

         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_data_in  = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         p2_ff        <= 1'b0;
         freed_ff     <= 1'b0;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         p2_ff        <= p2_in;
         freed_ff     <= freed_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff     <= kind_in;
      note_ff     <= note_in;
      vel_ff      <= vel_in;
      nv_ff       <= nv_in;
      rptr_ff     <= rptr_in;
      wptr_ff     <= wptr_in;
      w_ff        <= w_in;
      vidx_ff     <= vidx_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   // voice table
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_VOICES; i++) begin
            voice_busy_ff[i] <= 1'b0;
         end
      end else if (v_we) begin
         voice_busy_ff[vidx_ff] <= v_wbusy;
      end
      if (v_we) begin
         voice_pitch_ff[vidx_ff] <= v_wpitch;
      end
   end

   // held stack memory
   always_ff @(posedge clock) begin
      if (stack_we) begin
         stack_mem[stack_waddr] <= stack_wdata;
      end
      stack_q_ff <= stack_mem[stack_raddr];
   end

   // per-note memory
   always_ff @(posedge clock) begin
      if (note_we) begin
         note_mem[note_waddr] <= note_wdata;
      end
      note_q_ff <= note_mem[note_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NOTE_COUNT; i++) begin
            note_vld_ff[i] <= 1'b0;
         end
         note_qv_ff <= 1'b0;
      end else begin
         if (note_we) begin
            note_vld_ff[note_waddr] <= 1'b1;
         end
         note_qv_ff <= note_vld_ff[note_raddr];
      end
   end

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   `VAS_NEVER(a_cnt_range, clock, reset, cnt_ff > CW'(STACK_DEPTH), "held count over depth")
   `VAS_ASSERT(a_cnt_change, clock, reset, (!$past(reset) && (cnt_ff != $past(cnt_ff))) |-> ($past(state_ff) == ST_LOOKUP || $past(state_ff) == ST_COMPACT), "held count moved outside push or compaction")
   `VAS_NEVER(a_drop_quiet, clock, reset, rsp_valid_ff && rsp_data_ff.event_dropped && rsp_data_ff.voice_changed, "dropped event reports a voice change")

endmodule

`default_nettype wire

/* sim/voice_allocator_with_stealing_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// voice_allocator_with_stealing_tb
// self-checking bench for the polyphonic voice allocator
// ----------------------------------------------------------------------------
// Note events go in over the req channel and the voice change reports come
// back over the rsp channel. A predictor in the bench keeps its own held-note
// stack, note tables and voice table, computes the report of every accepted
// event and queues it. Each rsp transfer is compared field by field with the
// oldest queued report. A short directed run covers the corner cases, then
// random note traffic runs at several voice counts with random idling, and a run with none.
// ----------------------------------------------------------------------------

module voice_allocator_with_stealing_tb;
   import vas_pkg::*;

   localparam int MAX_V         = MAX_VOICES_DEFAULT;
   localparam int STACK_D       = STACK_DEPTH_DEFAULT;
   localparam int CYCLE_LIMIT   = 1_000_000;
   // longest note-off walk of the block, used as the tail at the end
   localparam int SETTLE_CYCLES = 2 * STACK_D + MAX_V + 8;
   localparam logic [CSR_ADDR_W-1:0] VCOUNT_ADDR = {REG_VOICE_COUNT, 2'b00};

   // shape of the random note traffic
   typedef enum int {MODE_FILL, MODE_MIXED, MODE_RELEASE} traffic_mode_e;

   // dut ports, all inputs known from time zero
   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   vas_req_type           req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b1;
   vas_rsp_type           rsp_data;
   logic                  psel      = 1'b0;
   logic                  penable   = 1'b0;
   logic                  pwrite    = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr     = '0;
   logic [CSR_DATA_W-1:0] pwdata    = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // idling controls
   bit idle_enable = 1'b1;
   int gap_pct     = 20;
   int stall_pct   = 15;
   int stall_left  = 0;

   // bookkeeping
   vas_rsp_type pending_results[$];
   vas_rsp_type expected_rsp;
   vas_rsp_type last_prediction;
   int          error_count  = 0;
   int          result_count = 0;
   int          cycle_count  = 0;
   int          pool_base    = 40;

   // allocator state as the bench sees it, reset values are zero but for the voice count
   logic [VCOUNT_W-1:0] cfg_voice_count = VCOUNT_RESET;
   bit                  vbusy      [MAX_V];
   bit [NOTE_W-1:0]     vpitch     [MAX_V];
   bit [VEL_W-1:0]      vlevel     [MAX_V];
   int                  last_voice = 0;
   bit [NOTE_W-1:0]     held_notes [STACK_D];
   int                  held_depth = 0;
   bit [VEL_W-1:0]      note_vel   [NOTE_COUNT];
   bit                  note_sounding [NOTE_COUNT];

   voice_allocator_with_stealing #(
      .MAX_VOICES  (MAX_V),
      .STACK_DEPTH (STACK_D)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   // 2 ns clock
   initial begin
      forever #1 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------

   // position of a note in the held stack, -1 if not held
   function automatic int held_slot(input bit [NOTE_W-1:0] n);
      for (int i = 0; i < held_depth; i++) begin
         if (held_notes[i] == n) return i;
      end
      return -1;
   endfunction

   function automatic vas_rsp_type voice_change(input int v, input bit act,
         input bit [NOTE_W-1:0] n, input bit [VEL_W-1:0] vel, input bit stolen);
      vas_rsp_type r;
      r                = '0;
      r.voice_changed  = 1'b1;
      r.voice_index    = v[VIDX_OUT_W-1:0];
      r.voice_active   = act;
      r.voice_note     = n;
      r.voice_velocity = vel;
      r.note_stolen    = stolen;
      return r;
   endfunction

   // applies one event to the bench state and returns the report it causes
   function automatic vas_rsp_type predict_voice_change(input vas_req_type ev);
      vas_rsp_type     r;
      int              nv;
      int              pos;
      int              freed;
      int              tgt;
      bit [NOTE_W-1:0] n;
      bit [NOTE_W-1:0] w;
      r  = '0;
      n  = ev.note_number;
      // voice count clamped to 1..MAX_V
      nv = cfg_voice_count;
      if (nv < 1) nv = 1;
      if (nv > MAX_V) nv = MAX_V;

      if (ev.req_type == REQ_NOTE_ON) begin
         // already held: nothing happens
         if (held_slot(n) >= 0) return r;
         // full stack: event lost, state untouched
         if (held_depth >= STACK_D) begin
            r.event_dropped = 1'b1;
            return r;
         end
         for (int i = held_depth; i > 0; i--) held_notes[i] = held_notes[i-1];
         held_notes[0]    = n;
         held_depth++;
         note_vel[n]      = ev.velocity;
         note_sounding[n] = 1'b1;
         // first free voice in range
         for (int i = 0; i < nv; i++) begin
            if (!vbusy[i]) begin
               vbusy[i]   = 1'b1;
               vpitch[i]  = n;
               vlevel[i]  = ev.velocity;
               last_voice = i;
               return voice_change(i, 1'b1, n, ev.velocity, 1'b0);
            end
         end
         // steal the last changed voice (voice 0 if it is out of range), last_voice is left as it is
         tgt = (last_voice < nv) ? last_voice : 0;
         if (vbusy[tgt]) note_sounding[vpitch[tgt]] = 1'b0;
         vbusy[tgt]       = 1'b1;
         vpitch[tgt]      = n;
         vlevel[tgt]      = ev.velocity;
         note_sounding[n] = 1'b1;
         return voice_change(tgt, 1'b1, n, ev.velocity, 1'b1);
      end

      // note off: squeeze the note out of the stack if it is there
      pos = held_slot(n);
      if (pos >= 0) begin
         for (int i = pos; i + 1 < held_depth; i++) held_notes[i] = held_notes[i+1];
         held_depth--;
      end
      note_vel[n]      = '0;
      note_sounding[n] = 1'b0;

      freed = -1;
      for (int i = 0; i < nv; i++) begin
         if (vbusy[i] && vpitch[i] == n) begin
            vbusy[i]   = 1'b0;
            vpitch[i]  = '0;
            vlevel[i]  = '0;
            last_voice = i;
            freed      = i;
            break;
         end
      end
      // one voice: voice 0 always plays the newest held note
      if (nv == 1 && held_depth > 0) begin
         w          = held_notes[0];
         vbusy[0]   = 1'b1;
         vpitch[0]  = w;
         vlevel[0]  = note_vel[w];
         last_voice = 0;
         return voice_change(0, 1'b1, w, note_vel[w], 1'b0);
      end
      if (freed >= 0) begin
         // hand the voice to the most recent held note without one
         for (int i = 0; i < held_depth; i++) begin
            w = held_notes[i];
            if (!note_sounding[w]) begin
               vbusy[freed]     = 1'b1;
               vpitch[freed]    = w;
               vlevel[freed]    = note_vel[w];
               note_sounding[w] = 1'b1;
               last_voice       = freed;
               return voice_change(freed, 1'b1, w, note_vel[w], 1'b0);
            end
         end
         return voice_change(freed, 1'b0, '0, '0, 1'b0);
      end
      return r;
   endfunction

   // ------------------------------------------------------------------
   // helpers
   // ------------------------------------------------------------------

   function automatic void note_error(input string msg);
      error_count++;
      if (error_count <= 10) $display("ERROR: %s", msg);
   endfunction

   function automatic string rsp_text(input vas_rsp_type r);
      return $sformatf("chg=%0b idx=%0d act=%0b note=%0d vel=%0d stolen=%0b drop=%0b",
         r.voice_changed, r.voice_index, r.voice_active, r.voice_note,
         r.voice_velocity, r.note_stolen, r.event_dropped);
   endfunction

   function automatic vas_req_type make_event(input logic kind, input int n, input int vel);
      vas_req_type ev;
      ev.req_type    = kind;
      ev.note_number = n[NOTE_W-1:0];
      ev.velocity    = vel[VEL_W-1:0];
      return ev;
   endfunction

   // random event: mostly plausible note traffic, some stray offs and repeats
   function automatic vas_req_type random_event(input traffic_mode_e mode);
      int   on_pct;
      int   n;
      logic kind;
      on_pct = (mode == MODE_FILL) ? 75 : (mode == MODE_MIXED) ? 55 : 25;
      kind   = ($urandom_range(0, 99) < on_pct) ? REQ_NOTE_ON : REQ_NOTE_OFF;
      if (kind == REQ_NOTE_OFF && held_depth > 0 && $urandom_range(0, 9) < 8)
         n = held_notes[$urandom_range(0, held_depth - 1)];
      else if ($urandom_range(0, 9) < 7)
         n = pool_base + $urandom_range(0, 47);
      else
         n = $urandom_range(0, 127);
      return make_event(kind, n, $urandom_range(0, 127));
   endfunction

   // one req transfer, prediction queued when it is accepted
   task automatic send_event(input vas_req_type ev);
      req_valid <= 1'b1;
      req_data  <= ev;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      last_prediction = predict_voice_change(ev);
      pending_results.push_back(last_prediction);
      // sender gap, valid stays up otherwise
      if (idle_enable && $urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   // hold off until every report is back and the block is idle
   task automatic wait_quiet();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input logic [CSR_DATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic csr_read(input logic [CSR_ADDR_W-1:0] addr, output logic [CSR_DATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= addr;
      @(posedge clock);
      penable <= 1'b1;
      // sample mid access phase, away from the edge
      @(negedge clock);
      data = prdata;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic check_voice_count_reg();
      logic [CSR_DATA_W-1:0] rd;
      csr_read(VCOUNT_ADDR, rd);
      if (rd[VCOUNT_W-1:0] !== cfg_voice_count)
         note_error($sformatf("voice_count read %0d, expected %0d",
            rd[VCOUNT_W-1:0], cfg_voice_count));
   endtask

   // register change only while idle
   task automatic set_voice_count(input int n);
      wait_quiet();
      csr_write(VCOUNT_ADDR, CSR_DATA_W'(n));
      cfg_voice_count = n[VCOUNT_W-1:0];
      check_voice_count_reg();
   endtask

   // ------------------------------------------------------------------
   // result side
   // ------------------------------------------------------------------

   // receiver stalls at random, in bursts
   always @(posedge clock) begin
      if (reset || !idle_enable) begin
         rsp_ready  <= 1'b1;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 99) < stall_pct) begin
         rsp_ready  <= 1'b0;
         stall_left <= $urandom_range(0, 11);
      end else begin
         rsp_ready  <= 1'b1;
      end
   end

   // every rsp transfer against the oldest queued report
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            note_error($sformatf("report with nothing pending: %s", rsp_text(rsp_data)));
         end else begin
            expected_rsp = pending_results.pop_front();
            if (rsp_data.voice_changed  !== expected_rsp.voice_changed  ||
                rsp_data.voice_index    !== expected_rsp.voice_index    ||
                rsp_data.voice_active   !== expected_rsp.voice_active   ||
                rsp_data.voice_note     !== expected_rsp.voice_note     ||
                rsp_data.voice_velocity !== expected_rsp.voice_velocity ||
                rsp_data.note_stolen    !== expected_rsp.note_stolen    ||
                rsp_data.event_dropped  !== expected_rsp.event_dropped)
               note_error($sformatf("report %0d expected %s got %s", result_count,
                  rsp_text(expected_rsp), rsp_text(rsp_data)));
            result_count++;
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("voice_allocator_with_stealing verification failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // register comes out of reset at its default
   task automatic test_csr_reset();
      check_voice_count_reg();
   endtask

   // full voice count: free voices, repeats, stray note off, release
   task automatic test_basic_notes();
      send_event(make_event(REQ_NOTE_ON, 0, 0));        // lowest note and velocity
      send_event(make_event(REQ_NOTE_ON, 127, 127));    // highest note and velocity
      send_event(make_event(REQ_NOTE_ON, 127, 5));      // repeat of a held note
      send_event(make_event(REQ_NOTE_OFF, 5, 127));     // note off of a note never held
      send_event(make_event(REQ_NOTE_ON, 40, 64));
      send_event(make_event(REQ_NOTE_ON, 41, 1));
      send_event(make_event(REQ_NOTE_OFF, 0, 0));       // frees a voice, nobody waiting
   endtask

   // two voices with busy voices above the count
   task automatic test_voice_stealing();
      set_voice_count(2);
      send_event(make_event(REQ_NOTE_ON, 10, 100));
      send_event(make_event(REQ_NOTE_ON, 20, 90));      // no free voice: steal
      send_event(make_event(REQ_NOTE_OFF, 20, 3));      // voice goes back to a waiting note
      send_event(make_event(REQ_NOTE_OFF, 40, 0));      // its voice is out of range now
      send_event(make_event(REQ_NOTE_OFF, 127, 127));
      send_event(make_event(REQ_NOTE_ON, 85, 42));
   endtask

   // one voice, last note priority
   task automatic test_mono_priority();
      set_voice_count(1);
      send_event(make_event(REQ_NOTE_ON, 60, 70));
      send_event(make_event(REQ_NOTE_ON, 64, 80));
      send_event(make_event(REQ_NOTE_OFF, 64, 0));      // back to the newest held note
      send_event(make_event(REQ_NOTE_OFF, 99, 0));      // unheld note off still reports voice 0
      send_event(make_event(REQ_NOTE_OFF, 60, 0));
   endtask

   // fill the held stack, overflow it, then let part of it go
   task automatic test_stack_full();
      int n;
      set_voice_count(15);
      while (held_depth < STACK_D) begin
         do n = $urandom_range(0, 127); while (held_slot(n) >= 0);
         send_event(make_event(REQ_NOTE_ON, n, $urandom_range(0, 127)));
      end
      repeat (2) begin
         do n = $urandom_range(0, 127); while (held_slot(n) >= 0);
         send_event(make_event(REQ_NOTE_ON, n, $urandom_range(0, 127)));
      end
      // repeat wins over the full check
      send_event(make_event(REQ_NOTE_ON, held_notes[0], 11));
      repeat (20) begin
         send_event(make_event(REQ_NOTE_OFF, held_notes[$urandom_range(0, held_depth - 1)],
            $urandom_range(0, 127)));
      end
   endtask

   // random segments of note traffic at a series of voice counts
   task automatic test_random_traffic(input int target);
      int            counts [12] = '{8, 3, 15, 1, 0, 5, 2, 9, 4, 7, 6, 8};
      int            done_items;
      int            seg_left;
      traffic_mode_e mode;
      for (int p = 0; p < 12; p++) begin
         set_voice_count(counts[p]);
         pool_base  = $urandom_range(0, 80);
         done_items = 0;
         seg_left   = 0;
         mode       = MODE_FILL;
         while (done_items < target / 12) begin
            if (seg_left == 0) begin
               seg_left  = $urandom_range(15, 40);
               mode      = traffic_mode_e'($urandom_range(0, 2));
               gap_pct   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 40);
               stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 40);
            end
            send_event(random_event(mode));
            seg_left--;
            // events the block just ignores do not count
            if (last_prediction.voice_changed || last_prediction.event_dropped)
               done_items++;
         end
      end
   endtask

   // no idling on either side
   task automatic test_back_to_back(input int target);
      int done_items;
      set_voice_count(8);
      idle_enable = 1'b0;
      done_items  = 0;
      while (done_items < target) begin
         send_event(random_event(traffic_mode_e'($urandom_range(0, 2))));
         if (last_prediction.voice_changed || last_prediction.event_dropped)
            done_items++;
      end
   endtask

   initial begin
      // reset held from time zero, then released
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_csr_reset();
      test_basic_notes();
      test_voice_stealing();
      test_mono_priority();
      test_stack_full();
      test_random_traffic(1300);
      test_back_to_back(150);

      // all events sent: wait for the last reports, then a quiet tail
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("voice_allocator_with_stealing verification clean");
      end else begin
         $display("voice_allocator_with_stealing verification failed");
      end
      $finish;
   end

endmodule
